/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the scheduler.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while arst_n is low.
`define SPMFS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define SPMFS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/spmfs_pkg.sv */
// Shared types and constants of the strict-priority multi-FIFO scheduler.
// No dependencies; used by every module and interface of the block but spmfs_ram.
`default_nettype none

package spmfs_pkg;

	localparam int NUM_LEVELS_DEF  = 6;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TAG_WIDTH       = 16;
	localparam int DUR_WIDTH       = 16;
	localparam int LEVEL_WIDTH     = 3;
	localparam int STATUS_WIDTH    = 2;

	typedef enum logic {
		OP_ADD,
		OP_STEP
	} op_t;

	typedef enum logic [STATUS_WIDTH-1:0] {
		STATUS_OK,
		STATUS_EMPTY,
		STATUS_FULL,
		STATUS_BAD_LEVEL
	} status_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_RESULT
	} fsm_state_t;

	// Controller to datapath command.
	typedef struct packed {
		logic exec;
	} ctl_cmd_t;

endpackage

`default_nettype wire

/* rtl/spmfs_req_if.sv */
// Request and response channel interfaces of the scheduler.
// Depends on spmfs_pkg for field widths.
`default_nettype none

interface spmfs_req_if
	import spmfs_pkg::*;
	();
	logic                   valid;
	logic                   ready;
	logic                   op;
	logic [TAG_WIDTH-1:0]   process_tag;
	logic [DUR_WIDTH-1:0]   duration;
	logic [LEVEL_WIDTH-1:0] level;

	modport source (output valid, op, process_tag, duration, level, input ready);
	modport sink (input valid, op, process_tag, duration, level, output ready);
endinterface

interface spmfs_rsp_if
	import spmfs_pkg::*;
	();
	logic                    valid;
	logic                    ready;
	logic [STATUS_WIDTH-1:0] status;
	logic [TAG_WIDTH-1:0]    out_tag;
	logic [DUR_WIDTH-1:0]    out_duration;
	logic [LEVEL_WIDTH-1:0]  out_level;

	modport source (output valid, status, out_tag, out_duration, out_level, input ready);
	modport sink (input valid, status, out_tag, out_duration, out_level, output ready);
endinterface

`default_nettype wire

/* rtl/strict_priority_multi_fifo_scheduler_core.sv */
// Top level of the strict-priority multi-FIFO scheduler.
// Depends on spmfs_pkg, spmfs_req_if/spmfs_rsp_if, spmfs_ctrl and spmfs_datapath.
`default_nettype none

// Keeps NUM_LEVELS ring FIFOs of QUEUE_DEPTH entries, level 0 most urgent. An add
// appends tag and duration to its level's queue (status full or bad level on
// refusal); a step pops the head of the lowest-numbered nonempty queue (status empty
// if none). One item is handled at a time: the result is offered from the cycle after
// the request is taken. The controller holds one item at a time and takes no request
// while a result waits; the registered read port of the entry memory, which holds
// NUM_LEVELS*QUEUE_DEPTH entries, puts the result out in the cycle after the transfer.
// The memory needs no clearing after reset since the per-level fill counts guard
// every read.
module strict_priority_multi_fifo_scheduler_core
	import spmfs_pkg::*;
#(
	parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	spmfs_req_if.sink   req,
	spmfs_rsp_if.source rsp
);

	ctl_cmd_t cmd;

	spmfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	spmfs_datapath #(
		.NUM_LEVELS  (NUM_LEVELS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.op           (req.op),
		.process_tag  (req.process_tag),
		.duration     (req.duration),
		.level        (req.level),
		.status       (rsp.status),
		.out_tag      (rsp.out_tag),
		.out_duration (rsp.out_duration),
		.out_level    (rsp.out_level)
	);

endmodule

`default_nettype wire

/* rtl/spmfs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module spmfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 96
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

/* rtl/spmfs_ctrl.sv */
// Handshake controller: accepts one request, holds the result until taken.
// Depends on spmfs_pkg.
`default_nettype none

module spmfs_ctrl
	import spmfs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	output ctl_cmd_t      cmd
);

	fsm_state_t state_q;
	fsm_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (in_valid) begin
					state_next = FSM_RESULT;
				end
			end
			FSM_RESULT: begin
				if (out_ready) begin
					state_next = FSM_IDLE;
				end
			end
			default: state_next = FSM_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			FSM_IDLE:   in_ready = 1'b1;
			FSM_RESULT: out_valid = 1'b1;
			default: begin
				in_ready  = 1'b0;
				out_valid = 1'b0;
			end
		endcase
		cmd.exec = in_valid && in_ready;
	end

endmodule

`default_nettype wire

/* rtl/spmfs_datapath.sv */
// Queue bookkeeping, priority pick, entry memory and result register.
// Depends on spmfs_pkg and spmfs_ram.
`default_nettype none

module spmfs_datapath
	import spmfs_pkg::*;
#(
	parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire ctl_cmd_t                cmd,
	input  wire logic                    op,
	input  wire logic [TAG_WIDTH-1:0]    process_tag,
	input  wire logic [DUR_WIDTH-1:0]    duration,
	input  wire logic [LEVEL_WIDTH-1:0]  level,
	output logic      [STATUS_WIDTH-1:0] status,
	output logic      [TAG_WIDTH-1:0]    out_tag,
	output logic      [DUR_WIDTH-1:0]    out_duration,
	output logic      [LEVEL_WIDTH-1:0]  out_level
);

	localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int DEPTH  = NUM_LEVELS * QUEUE_DEPTH;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int MEM_W  = TAG_WIDTH + DUR_WIDTH;

	logic [PTR_W-1:0] head_q  [NUM_LEVELS];
	logic [PTR_W-1:0] tail_q  [NUM_LEVELS];
	logic [CNT_W-1:0] count_q [NUM_LEVELS];

	logic [NUM_LEVELS-1:0] nonempty;
	logic [NUM_LEVELS-1:0] full_vec;
	logic [LVL_W-1:0]      pick;
	logic                  found;
	logic [LVL_W-1:0]      add_idx;
	logic                  level_ok;
	logic                  is_add;
	logic                  do_add;
	logic                  do_step;
	logic [PTR_W-1:0]      tail_sel;
	logic [PTR_W-1:0]      head_sel;
	logic [ADDR_W-1:0]     wr_addr;
	logic [ADDR_W-1:0]     rd_addr;
	logic [MEM_W-1:0]      rd_data;
	status_t               status_next;

	status_t               status_q;
	logic                  from_ram_q;
	logic [LVL_W-1:0]      pick_q;

	always_comb begin
		for (int i = 0; i < NUM_LEVELS; i++) begin
			nonempty[i] = (count_q[i] != '0);
			full_vec[i] = (count_q[i] == CNT_W'(QUEUE_DEPTH));
		end
	end

	// Lowest-numbered nonempty level wins.
	always_comb begin
		pick = '0;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (nonempty[i]) begin
				pick = LVL_W'(i);
			end
		end
		found = |nonempty;
	end

	assign is_add   = (op == OP_ADD);
	assign level_ok = ({1'b0, level} < (LEVEL_WIDTH + 1)'(NUM_LEVELS));
	assign add_idx  = level[LVL_W-1:0];
	assign do_add   = cmd.exec && is_add && level_ok && !full_vec[add_idx];
	assign do_step  = cmd.exec && !is_add && found;

	assign tail_sel = tail_q[add_idx];
	assign head_sel = head_q[pick];
	assign wr_addr  = ADDR_W'(add_idx * QUEUE_DEPTH) + ADDR_W'(tail_sel);
	assign rd_addr  = ADDR_W'(pick * QUEUE_DEPTH) + ADDR_W'(head_sel);

	always_comb begin
		if (is_add) begin
			if (!level_ok) begin
				status_next = STATUS_BAD_LEVEL;
			end else if (full_vec[add_idx]) begin
				status_next = STATUS_FULL;
			end else begin
				status_next = STATUS_OK;
			end
		end else begin
			status_next = found ? STATUS_OK : STATUS_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				if (do_add && (add_idx == LVL_W'(i))) begin
					tail_q[i]  <= (tail_q[i] == PTR_W'(QUEUE_DEPTH - 1)) ?
						'0 : tail_q[i] + 1'b1;
					count_q[i] <= count_q[i] + 1'b1;
				end
				if (do_step && (pick == LVL_W'(i))) begin
					head_q[i]  <= (head_q[i] == PTR_W'(QUEUE_DEPTH - 1)) ?
						'0 : head_q[i] + 1'b1;
					count_q[i] <= count_q[i] - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q   <= status_next;
			from_ram_q <= do_step;
			pick_q     <= pick;
		end
	end

	spmfs_ram #(
		.WIDTH (MEM_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (do_add),
		.wr_addr (wr_addr),
		.wr_data ({duration, process_tag}),
		.rd_en   (do_step),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Read data stays put until the next step, so it can feed the result directly.
	assign status       = status_q;
	assign out_tag      = from_ram_q ? rd_data[TAG_WIDTH-1:0] : '0;
	assign out_duration = from_ram_q ? rd_data[MEM_W-1:TAG_WIDTH] : '0;
	assign out_level    = from_ram_q ? LEVEL_WIDTH'(pick_q) : '0;

endmodule

`default_nettype wire

/* rtl/spmfs_checker.sv */
// Port-level checker for the scheduler top level, attached by bind.
// Depends on spmfs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module spmfs_checker
	import spmfs_pkg::*;
#(
	parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    req_valid,
	input wire logic                    req_ready,
	input wire logic                    req_op,
	input wire logic [LEVEL_WIDTH-1:0]  req_level,
	input wire logic                    rsp_valid,
	input wire logic                    rsp_ready,
	input wire logic [STATUS_WIDTH-1:0] rsp_status,
	input wire logic [TAG_WIDTH-1:0]    rsp_tag,
	input wire logic [DUR_WIDTH-1:0]    rsp_duration,
	input wire logic [LEVEL_WIDTH-1:0]  rsp_level
);

	`SPMFS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_tag) && $stable(rsp_duration) && $stable(rsp_level), "response changed while stalled")
	`SPMFS_ASSERT(a_accept_then_result, req_valid && req_ready |=> rsp_valid, "no result after transfer")
	`SPMFS_ASSERT(a_one_at_a_time, rsp_valid |-> !req_ready, "request taken while result pending")
	`SPMFS_ASSERT(a_fail_zero, rsp_valid && (rsp_status != STATUS_OK) |-> (rsp_tag == '0) && (rsp_duration == '0) && (rsp_level == '0), "nonzero payload on failed item")
	`SPMFS_ASSERT(a_bad_level, req_valid && req_ready && (req_op == OP_ADD) && ({1'b0, req_level} >= (LEVEL_WIDTH + 1)'(NUM_LEVELS)) |=> rsp_status == STATUS_BAD_LEVEL, "bad level not flagged")

endmodule

bind strict_priority_multi_fifo_scheduler_core spmfs_checker #(
	.NUM_LEVELS (NUM_LEVELS)
) u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.req_op       (req.op),
	.req_level    (req.level),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_status   (rsp.status),
	.rsp_tag      (rsp.out_tag),
	.rsp_duration (rsp.out_duration),
	.rsp_level    (rsp.out_level)
);

`default_nettype wire
